// File: rtl/core/binarize_and_contour_filter_defines.svh
// Assertion macros shared by the binarize and contour filter RTL.
`ifndef BINARIZE_AND_CONTOUR_FILTER_DEFINES_SVH
`define BINARIZE_AND_CONTOUR_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off during reset.
`define BCF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcf: implication check failed");
// Next-cycle implication, sampled on clk_i, off during reset.
`define BCF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcf: next-cycle check failed");
`else
`define BCF_ASSERT_IMP(lbl, ante, cons)
`define BCF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/bcf_pkg.sv
// Shared constants, item types and stage command struct for the filter.
`timescale 1ns / 1ps
`default_nettype none
package bcf_pkg;

  // Frame geometry limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  // Pixel history ring: must hold two rows plus three pixels
  localparam int unsigned RING_AW    = $clog2(2 * MAX_WIDTH + 3);
  localparam int unsigned RING_DEPTH = 2 ** RING_AW;

  // Pending contour pixels, up to one row plus one
  localparam int unsigned PEND_W = $clog2(MAX_WIDTH + 2);

  // Config port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd3;

  localparam logic [7:0] THRESHOLD_RESET = 8'd220;
  localparam logic [7:0] FULL_LEVEL      = 8'd255;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // One ring entry: pixel plus its raster position
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pixel_t           pix;
  } entry_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [7:0] in_alpha;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last_pixel;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_BIN,
    OP_PUSH,
    OP_FLUSH,
    OP_REF_A,
    OP_REF_B
  } op_e;

  // Command from the sequencer into the ring / window stage
  typedef struct packed {
    logic               valid;
    op_e                op;
    logic               emit;
    logic               wr_en;
    logic [RING_AW-1:0] wr_addr;
    logic [RING_AW-1:0] rd_a;
    logic [RING_AW-1:0] rd_b;
    entry_t             wr_data;
    out_item_t          bin;
  } req_t;

  typedef struct packed {
    logic [WID_W-1:0] wid;
    logic [HGT_W-1:0] hgt;
  } geo_t;

endpackage
`default_nettype wire

// File: rtl/core/binarize_and_contour_filter.sv
// Top level of the binarize and contour filter.
//
//  channel | signals                             | direction | transfer
//  --------+-------------------------------------+-----------+------------------------
//  in      | in_valid_i, in_stall_o, in_item_i   | sink      | valid high, stall low
//  out     | out_valid_o, out_stall_i, out_item_o| source    | valid high, stall low
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_*_i   | sink      | valid and ready high
//
// One item per clock while the input is not stalled. A result is registered in
// the window stage and then written to the result queue before it reaches the
// output; in contour mode a pixel is answered by the pixel one row plus one
// later (or by a flush). A contour pixel does one write and two reads of the
// history ring in the cycle it is taken; a flush does one read. A frame_width
// write stalls the input while the window reloads from the ring. No clearing
// pass after reset. The four-entry result queue keeps input flowing while the
// output stalls; input stalls once queue fill plus the item in flight is four.
`timescale 1ns / 1ps
`default_nettype none
`include "binarize_and_contour_filter_defines.svh"
module binarize_and_contour_filter
  import bcf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  req_t                  req;
  geo_t                  geo;
  logic                  s1_valid;
  logic                  res_push;
  out_item_t             res;
  logic [FIFO_CNT_W-1:0] fifo_cnt;
  logic                  ref_busy;

  // Sequencer: config, position, pending count, ring addresses
  bcf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s1_valid_i  (s1_valid),
    .fifo_cnt_i  (fifo_cnt),
    .req_o       (req),
    .geo_o       (geo),
    .ref_busy_o  (ref_busy)
  );

  // Ring memory and 3x3 window
  bcf_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .geo_i      (geo),
    .s1_valid_o (s1_valid),
    .push_o     (res_push),
    .res_o      (res)
  );

  // Result queue
  bcf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .data_i      (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .count_o     (fifo_cnt)
  );

  // Credit scheme must leave room for every result produced
  `BCF_ASSERT_IMP(a_fifo_room, res_push, fifo_cnt != FIFO_CNT_W'(FIFO_DEPTH))
  // A width write always starts a window reload
  `BCF_ASSERT_NXT(a_width_reload, cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_WIDTH), ref_busy)
  // No item enters while the window reloads
  `BCF_ASSERT_IMP(a_reload_blocks_input, ref_busy, in_stall_o && !cfg_ready_o)

endmodule
`default_nettype wire

// File: rtl/core/bcf_out_fifo.sv
// Four-entry result queue between the window stage and the output port.
`timescale 1ns / 1ps
`default_nettype none
module bcf_out_fifo
  import bcf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire out_item_t             data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  output logic [FIFO_CNT_W-1:0]      count_o
);

  out_item_t             fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = fifo_q[rd_ptr_q];
  assign count_o     = cnt_q;
  assign pop         = out_valid_o && !out_stall_i;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + FIFO_AW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + FIFO_AW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + FIFO_CNT_W'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bcf_window.sv
// Pixel history ring memory, 3x3 dark-flag window and result stage.
`timescale 1ns / 1ps
`default_nettype none
module bcf_window
  import bcf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire req_t      req_i,
  input  wire geo_t      geo_i,
  output logic           s1_valid_o,
  output logic           push_o,
  output out_item_t      res_o
);

  // Ring memory: one write and two reads per cycle, read data registered
  entry_t ring_mem [RING_DEPTH];
  entry_t rd_a_q, rd_b_q;
  req_t   s1_q;
  logic   s1_valid_q;

  // Window state: row0 newest pixels, row1 one row back, row2 two rows back.
  // Bit 0 is the newer of the two held flags.
  logic [1:0] row0_q, row0_d;
  logic [1:0] row1_q, row1_d;
  logic [1:0] row2_q, row2_d;
  entry_t     ctr_q, ctr_d;

  logic       dark_in, dark_a, dark_b, any_dark;
  entry_t     ent;
  logic       interior, core_hit, zero_g;
  logic [7:0] g_val;

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.wr_en) begin
      ring_mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.valid) begin
      rd_a_q <= ring_mem[req_i.rd_a];
      rd_b_q <= ring_mem[req_i.rd_b];
      s1_q   <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.valid;
    end
  end

  assign s1_valid_o = s1_valid_q;

  // Dark flags of the incoming pixel and the two ring reads
  assign dark_in = (s1_q.wr_data.pix.red == 8'd0);
  assign dark_a  = (rd_a_q.pix.red == 8'd0);
  assign dark_b  = (rd_b_q.pix.red == 8'd0);

  // Eight neighbors of the center (center is row1 bit 0)
  assign any_dark = dark_in | row0_q[0] | row0_q[1] |
                    dark_a  | row1_q[1] |
                    dark_b  | row2_q[0] | row2_q[1];

  // Flush answers a ring entry directly; push answers the held center
  assign ent = (s1_q.op == OP_FLUSH) ? rd_a_q : ctr_q;

  assign interior = (ent.col != '0) &&
                    ((WID_W'(ent.col) + WID_W'(2)) <= geo_i.wid) &&
                    (ent.row != '0) &&
                    ((HGT_W'(ent.row) + HGT_W'(2)) <= geo_i.hgt);

  assign core_hit = (s1_q.op == OP_PUSH) && (ent.pix.red == FULL_LEVEL) &&
                    interior && !any_dark;

  assign g_val  = core_hit ? 8'd0 : ent.pix.green;
  assign zero_g = (g_val == 8'd0);

  // Result build
  always_comb begin
    if (s1_q.op == OP_BIN) begin
      res_o = s1_q.bin;
    end else begin
      res_o.out_red    = zero_g ? 8'd0 : ent.pix.red;
      res_o.out_green  = g_val;
      res_o.out_blue   = zero_g ? 8'd0 : ent.pix.blue;
      res_o.out_alpha  = ent.pix.alpha;
      res_o.last_pixel = (WID_W'(ent.col) == (geo_i.wid - WID_W'(1))) &&
                         (HGT_W'(ent.row) == (geo_i.hgt - HGT_W'(1)));
    end
  end

  assign push_o = s1_valid_q && s1_q.emit;

  // Window shift on push, reload after a width change
  always_comb begin
    row0_d = row0_q;
    row1_d = row1_q;
    row2_d = row2_q;
    ctr_d  = ctr_q;
    if (s1_valid_q) begin
      case (s1_q.op)
        OP_PUSH: begin
          row0_d = {row0_q[0], dark_in};
          row1_d = {row1_q[0], dark_a};
          row2_d = {row2_q[0], dark_b};
          ctr_d  = rd_a_q;
        end
        OP_REF_A: begin
          row1_d[0] = dark_a;
          row2_d[0] = dark_b;
          ctr_d     = rd_a_q;
        end
        OP_REF_B: begin
          row1_d[1] = dark_a;
          row2_d[1] = dark_b;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= '0;
      row1_q <= '0;
      row2_q <= '0;
      ctr_q  <= '0;
    end else begin
      row0_q <= row0_d;
      row1_q <= row1_d;
      row2_q <= row2_d;
      ctr_q  <= ctr_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bcf_seq.sv
// Config registers, raster position, pending count and ring address sequencer.
`timescale 1ns / 1ps
`default_nettype none
module bcf_seq
  import bcf_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  s1_valid_i,
  input  wire logic [FIFO_CNT_W-1:0] fifo_cnt_i,
  output req_t                       req_o,
  output geo_t                       geo_o,
  output logic                       ref_busy_o
);

  // Window reload sequence after a width write
  localparam logic [1:0] REF_IDLE = 2'd0;
  localparam logic [1:0] REF_A    = 2'd1;
  localparam logic [1:0] REF_B    = 2'd2;

  localparam int unsigned WID_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int unsigned HGT_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

  function automatic logic [WID_W-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v == '0) begin
      r = WID_W'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = WID_W'(MAX_WIDTH);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
    logic [HGT_W-1:0] r;
    if (v == '0) begin
      r = HGT_W'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = HGT_W'(MAX_HEIGHT);
    end else begin
      r = HGT_W'(v);
    end
    return r;
  endfunction

  logic                mode_q, mode_d;
  logic [7:0]          thr_q, thr_d;
  logic [WID_W-1:0]    wid_q, wid_d;
  logic [HGT_W-1:0]    hgt_q, hgt_d;
  logic [1:0]          ref_q, ref_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [PEND_W-1:0]   pend_q, pend_d;
  logic [RING_AW-1:0]  newest_q, newest_d;

  logic                cfg_acc, acc;
  logic [FIFO_CNT_W:0] occ;
  logic [RING_AW-1:0]  n1, w_ring, w2_ring;
  logic [PEND_W-1:0]   w_pend;
  logic                push_emit, bin_dark, col_wrap, row_wrap;
  logic [7:0]          bin_v;

  assign geo_o.wid  = wid_q;
  assign geo_o.hgt  = hgt_q;
  assign ref_busy_o = (ref_q != REF_IDLE);

  // Input credit: queue fill plus the item in flight
  assign occ         = (FIFO_CNT_W + 1)'(fifo_cnt_i) + (FIFO_CNT_W + 1)'(s1_valid_i);
  assign in_stall_o  = ref_busy_o || (occ >= (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign cfg_ready_o = !ref_busy_o && !s1_valid_i;

  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign acc     = in_valid_i && !in_stall_o;

  // Config writes and reload trigger
  always_comb begin
    mode_d = mode_q;
    thr_d  = thr_q;
    wid_d  = wid_q;
    hgt_d  = hgt_q;
    if (cfg_acc) begin
      case (cfg_index_i)
        REG_MODE:      mode_d = cfg_data_i[0];
        REG_THRESHOLD: thr_d  = cfg_data_i[7:0];
        REG_WIDTH:     wid_d  = clamp_w(cfg_data_i);
        REG_HEIGHT:    hgt_d  = clamp_h(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (ref_q)
      REF_IDLE: ref_d = (cfg_acc && (cfg_index_i == REG_WIDTH)) ? REF_A : REF_IDLE;
      REF_A:    ref_d = REF_B;
      REF_B:    ref_d = REF_IDLE;
      default:  ref_d = REF_IDLE;
    endcase
  end

  // Ring addressing helpers
  assign n1        = newest_q + RING_AW'(1);
  assign w_ring    = RING_AW'(wid_q);
  assign w2_ring   = w_ring << 1;
  assign w_pend    = PEND_W'(wid_q) + PEND_W'(1);
  assign push_emit = (pend_q >= w_pend);

  // Binarize path
  assign bin_dark = (in_item_i.in_red < thr_q) || (in_item_i.in_green < thr_q) ||
                    (in_item_i.in_blue < thr_q);
  assign bin_v    = bin_dark ? 8'd0 : FULL_LEVEL;

  assign col_wrap = (WID_W'(col_q) + WID_W'(1)) >= wid_q;
  assign row_wrap = (HGT_W'(row_q) + HGT_W'(1)) >= hgt_q;

  // Command build and state update
  always_comb begin
    req_o      = '0;
    req_o.op   = OP_BIN;
    col_d      = col_q;
    row_d      = row_q;
    pend_d     = pend_q;
    newest_d   = newest_q;

    req_o.bin.out_red    = bin_v;
    req_o.bin.out_green  = bin_v;
    req_o.bin.out_blue   = bin_v;
    req_o.bin.out_alpha  = in_item_i.in_alpha;
    req_o.bin.last_pixel = (WID_W'(col_q) == (wid_q - WID_W'(1))) &&
                           (HGT_W'(row_q) == (hgt_q - HGT_W'(1)));

    req_o.wr_data.pix.red   = in_item_i.in_red;
    req_o.wr_data.pix.green = in_item_i.in_green;
    req_o.wr_data.pix.blue  = in_item_i.in_blue;
    req_o.wr_data.pix.alpha = in_item_i.in_alpha;
    req_o.wr_data.col       = col_q;
    req_o.wr_data.row       = row_q;

    if (ref_q == REF_A) begin
      req_o.valid = 1'b1;
      req_o.op    = OP_REF_A;
      req_o.rd_a  = newest_q - w_ring;
      req_o.rd_b  = newest_q - w2_ring;
    end else if (ref_q == REF_B) begin
      req_o.valid = 1'b1;
      req_o.op    = OP_REF_B;
      req_o.rd_a  = newest_q - w_ring - RING_AW'(1);
      req_o.rd_b  = newest_q - w2_ring - RING_AW'(1);
    end else if (acc) begin
      req_o.valid = 1'b1;
      if (in_item_i.kind) begin
        // Flush: oldest pending pixel, no neighbor test
        req_o.op   = OP_FLUSH;
        req_o.emit = (pend_q != '0);
        req_o.rd_a = newest_q - RING_AW'(pend_q - PEND_W'(1));
        if (pend_q != '0) begin
          pend_d = pend_q - PEND_W'(1);
        end
      end else begin
        if (mode_q) begin
          req_o.op      = OP_PUSH;
          req_o.emit    = push_emit;
          req_o.wr_en   = 1'b1;
          req_o.wr_addr = n1;
          req_o.rd_a    = n1 - w_ring;
          req_o.rd_b    = n1 - w2_ring;
          newest_d      = n1;
          pend_d        = push_emit ? w_pend : (pend_q + PEND_W'(1));
        end else begin
          req_o.op   = OP_BIN;
          req_o.emit = 1'b1;
        end
        // Raster position advances in either mode
        if (col_wrap) begin
          col_d = '0;
          row_d = row_wrap ? '0 : (row_q + ROW_W'(1));
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      thr_q    <= THRESHOLD_RESET;
      wid_q    <= WID_W'(WID_RST);
      hgt_q    <= HGT_W'(HGT_RST);
      ref_q    <= REF_IDLE;
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
      newest_q <= '0;
    end else begin
      mode_q   <= mode_d;
      thr_q    <= thr_d;
      wid_q    <= wid_d;
      hgt_q    <= hgt_d;
      ref_q    <= ref_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pend_q   <= pend_d;
      newest_q <= newest_d;
    end
  end

endmodule
`default_nettype wire
